// ----- design/dpf_pkg.sv -----
// Shared types and constants for the distinct prime factor lister.
package dpf_pkg;

   localparam int FACTOR_W = 32;

   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_ONE  = 2'd1,
      ST_ZERO = 2'd2
   } status_type;

   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_START  = 6'b000010,
      S_STRIP  = 6'b000100,
      S_DIV    = 6'b001000,
      S_DECIDE = 6'b010000,
      S_FINAL  = 6'b100000
   } state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

// ----- design/dpf_req_if.sv -----
// Input channel carrying the value to factor.
interface dpf_req_if #(parameter int WIDTH = 32) ();
   logic             valid;
   logic             ready;
   logic [WIDTH-1:0] value;

   modport source (output valid, output value, input ready);
   modport sink (input valid, input value, output ready);
endinterface

// ----- design/dpf_rsp_if.sv -----
// Result channel carrying one prime factor per item.
interface dpf_rsp_if import dpf_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [FACTOR_W-1:0] factor;
   logic                is_last;
   logic [1:0]          status;

   modport source (output valid, output factor, output is_last, output status, input ready);
   modport sink (input valid, input factor, input is_last, input status, output ready);
endinterface

// ----- design/distinct_prime_factor_lister_core.sv -----
// Top level: trial division sequencer with output register around the serial divider.
//
//   channel  dir  fields                   accepted when
//   req_ch   in   value[WIDTH-1:0]         valid && ready
//   rsp_ch   out  factor, is_last, status  valid && ready
//
// One item is worked at a time; req_ch.ready is high only while idle.
// Factors of two are stripped by shifting; each odd trial divisor is tested by the
// bit-serial divider, so a prime input near 2**WIDTH needs about
// 2**(WIDTH/2 - 1) trial divisors.
// Reset is synchronous and clears the sequencer and the output valid.
// A stalled result only holds the sequencer when the next factor must be sent.
module distinct_prime_factor_lister_core
   import dpf_pkg::*;
#(
   parameter int WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   dpf_req_if.sink     req_ch,
   dpf_rsp_if.source   rsp_ch
);

   state_type        state_ff, state_in;
   logic [WIDTH-1:0] rem_ff, rem_in;
   logic [WIDTH-1:0] p_ff, p_in;
   logic [WIDTH-1:0] pend_ff, pend_in;
   logic             have_pend_ff, have_pend_in;
   logic             emitted_ff, emitted_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [FACTOR_W-1:0] factor_ff, factor_in;
   logic                last_ff, last_in;
   status_type          status_ff, status_in;

   logic             push;
   logic [WIDTH-1:0] push_factor;
   logic [FACTOR_W-1:0] push_fac32;
   logic             push_last;
   status_type       push_status;
   logic             slot_free;

   logic             div_start;
   logic [WIDTH-1:0] div_dividend;
   logic [WIDTH-1:0] div_divisor;
   div_stat_type     div_stat;
   logic [WIDTH-1:0] quot;
   logic [WIDTH-1:0] remd;
   logic             r_zero;
   logic [WIDTH-1:0] p_next;

   dpf_div #(.WIDTH(WIDTH)) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .stat      (div_stat),
      .quotient  (quot),
      .remainder (remd)
   );

   assign slot_free     = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready  = (state_ff == S_IDLE);
   assign r_zero        = (remd == '0);
   assign p_next        = p_ff + WIDTH'(2);

   generate
      if (WIDTH >= FACTOR_W) begin : g_trunc
         assign push_fac32 = push_factor[FACTOR_W-1:0];
      end else begin : g_ext
         assign push_fac32 = {{(FACTOR_W - WIDTH){1'b0}}, push_factor};
      end
   endgenerate

   always_comb begin
      state_in     = state_ff;
      rem_in       = rem_ff;
      p_in         = p_ff;
      pend_in      = pend_ff;
      have_pend_in = have_pend_ff;
      emitted_in   = emitted_ff;
      push         = 1'b0;
      push_factor  = pend_ff;
      push_last    = 1'b0;
      push_status  = ST_OK;
      div_start    = 1'b0;
      div_dividend = rem_ff;
      div_divisor  = p_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_ch.valid) begin
               rem_in   = req_ch.value;
               state_in = S_START;
            end
         end
         S_START: begin
            if (rem_ff[WIDTH-1:1] == '0) begin
               if (slot_free) begin
                  push        = 1'b1;
                  push_factor = '0;
                  push_last   = 1'b1;
                  push_status = rem_ff[0] ? ST_ONE : ST_ZERO;
                  state_in    = S_IDLE;
               end
            end else if (!rem_ff[0]) begin
               pend_in      = WIDTH'(2);
               have_pend_in = 1'b1;
               state_in     = S_STRIP;
            end else begin
               have_pend_in = 1'b0;
               p_in         = WIDTH'(3);
               emitted_in   = 1'b0;
               div_start    = 1'b1;
               div_divisor  = WIDTH'(3);
               state_in     = S_DIV;
            end
         end
         S_STRIP: begin
            if (!rem_ff[0]) begin
               rem_in = rem_ff >> 1;
            end else begin
               p_in        = WIDTH'(3);
               emitted_in  = 1'b0;
               div_start   = 1'b1;
               div_divisor = WIDTH'(3);
               state_in    = S_DIV;
            end
         end
         S_DIV: begin
            if (div_stat.done) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (r_zero && emitted_ff) begin
               rem_in       = quot;
               div_start    = 1'b1;
               div_dividend = quot;
               state_in     = S_DIV;
            end else if (p_ff > quot) begin
               state_in = S_FINAL;
            end else if (!r_zero) begin
               p_in        = p_next;
               emitted_in  = 1'b0;
               div_start   = 1'b1;
               div_divisor = p_next;
               state_in    = S_DIV;
            end else if (!have_pend_ff || slot_free) begin
               push         = have_pend_ff;
               pend_in      = p_ff;
               have_pend_in = 1'b1;
               emitted_in   = 1'b1;
               rem_in       = quot;
               div_start    = 1'b1;
               div_dividend = quot;
               state_in     = S_DIV;
            end
         end
         S_FINAL: begin
            if (rem_ff[WIDTH-1:1] != '0) begin
               if (!have_pend_ff) begin
                  pend_in      = rem_ff;
                  have_pend_in = 1'b1;
                  rem_in       = WIDTH'(1);
               end else if (slot_free) begin
                  push    = 1'b1;
                  pend_in = rem_ff;
                  rem_in  = WIDTH'(1);
               end
            end else if (slot_free) begin
               push      = 1'b1;
               push_last = 1'b1;
               state_in  = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      factor_in    = factor_ff;
      last_in      = last_ff;
      status_in    = status_ff;
      if (push) begin
         rsp_valid_in = 1'b1;
         factor_in    = push_fac32;
         last_in      = push_last;
         status_in    = push_status;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         have_pend_ff <= 1'b0;
         emitted_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         have_pend_ff <= have_pend_in;
         emitted_ff   <= emitted_in;
      end
      rem_ff    <= rem_in;
      p_ff      <= p_in;
      pend_ff   <= pend_in;
      factor_ff <= factor_in;
      last_ff   <= last_in;
      status_ff <= status_in;
   end

   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.factor  = factor_ff;
   assign rsp_ch.is_last = last_ff;
   assign rsp_ch.status  = status_ff;

`ifndef ASSERT_OFF
   a_odd_divisor: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DECIDE) |-> (p_ff[0] && p_ff >= WIDTH'(3)))
      else $error("Trial divisor is not an odd number of at least three.");
   a_special_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && status_ff != ST_OK) |-> (factor_ff == '0 && last_ff))
      else $error("Special result carries a factor or is not last.");
   a_div_start_src: assert property (@(posedge clock) disable iff (reset)
      div_start |-> (state_ff == S_START || state_ff == S_STRIP || state_ff == S_DECIDE))
      else $error("Division started from an unexpected state.");
   a_final_has_pend: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FINAL && rem_ff[WIDTH-1:1] == '0) |-> have_pend_ff)
      else $error("Final result requested with no pending factor.");
`endif

endmodule

// ----- design/dpf_div.sv -----
// Bit-serial restoring divider producing one quotient bit per cycle.
module dpf_div
   import dpf_pkg::*;
#(
   parameter int WIDTH = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [WIDTH-1:0] dividend,
   input  logic [WIDTH-1:0] divisor,
   output div_stat_type     stat,
   output logic [WIDTH-1:0] quotient,
   output logic [WIDTH-1:0] remainder
);

   localparam int CW = $clog2(WIDTH + 1);

   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             done_ff, done_in;
   logic [WIDTH-1:0] d_ff, d_in;
   logic [WIDTH-1:0] r_ff, r_in;
   logic [WIDTH-1:0] div_ff, div_in;
   logic [WIDTH:0]   shifted;
   logic [WIDTH:0]   diff;
   logic             ge;
   logic             busy;

   assign busy    = (cnt_ff != '0);
   assign shifted = {r_ff, d_ff[WIDTH-1]};
   assign diff    = shifted - {1'b0, div_ff};
   assign ge      = (shifted >= {1'b0, div_ff});

   always_comb begin
      cnt_in  = cnt_ff;
      d_in    = d_ff;
      r_in    = r_ff;
      div_in  = div_ff;
      done_in = 1'b0;
      if (start) begin
         cnt_in = CW'(WIDTH);
         d_in   = dividend;
         r_in   = '0;
         div_in = divisor;
      end else if (busy) begin
         cnt_in  = cnt_ff - CW'(1);
         d_in    = {d_ff[WIDTH-2:0], ge};
         r_in    = ge ? diff[WIDTH-1:0] : shifted[WIDTH-1:0];
         done_in = (cnt_ff == CW'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      d_ff   <= d_in;
      r_ff   <= r_in;
      div_ff <= div_in;
   end

   assign stat.busy = busy;
   assign stat.done = done_ff;
   assign quotient  = d_ff;
   assign remainder = r_ff;

`ifndef ASSERT_OFF
   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      !(start && busy))
      else $error("Divider restarted while busy.");
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy))
      else $error("Divider done without a running division.");
   a_rem_below_div: assert property (@(posedge clock) disable iff (reset)
      (done_ff && div_ff != '0) |-> (r_ff < div_ff))
      else $error("Divider remainder not below divisor.");
`endif

endmodule

// ----- tb/sv/tb_distinct_prime_factor_lister_core.sv -----
// Self-checking testbench for the distinct prime factor lister core.
module tb_distinct_prime_factor_lister_core
   import dpf_pkg::*;
();

   localparam int VALUE_W = 32;
   localparam int unsigned OP_BUDGET = 250;
   localparam int unsigned NO_CAP = 32'hFFFF_FFFF;
   localparam int STALL_LIMIT = 50000;
   localparam int TAIL_CYCLES = 100;
   localparam int RANDOM_PER_PHASE = 27;
   localparam longint unsigned MAX_VALUE = 64'h0000_0000_FFFF_FFFF;
   localparam int unsigned SMALL_PRIMES [18] = '{
      2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37, 41, 43, 47, 53, 59, 61
   };
   localparam bit [VALUE_W-1:0] DIRECTED_VALUES [19] = '{
      32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd6, 32'd9, 32'd25, 32'd105, 32'd63001,
      32'd65521, 32'd131042, 32'd60466176, 32'd3486784401, 32'd223092870,
      32'h8000_0000, 32'h5555_5555, 32'hAAAA_AAAA, 32'hFFFF_FFFF
   };

   typedef struct packed {
      logic [FACTOR_W-1:0] factor;
      logic                is_last;
      status_type          status;
   } factor_result_type;

   logic clock;
   logic reset;

   dpf_req_if #(.WIDTH(VALUE_W)) req_ch ();
   dpf_rsp_if rsp_ch ();

   bit [VALUE_W-1:0]  pending_values[$];
   factor_result_type expected_factors[$];
   factor_result_type wanted;
   int unsigned       send_idle_pct;
   int unsigned       recv_idle_pct;
   int unsigned       values_queued;
   int unsigned       values_taken;
   int unsigned       error_count;
   int unsigned       quiet_cycles;

   distinct_prime_factor_lister_core #(.WIDTH(VALUE_W)) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always #4 clock = ~clock;

   // Lists the distinct prime factors of a value and returns the number of divider
   // operations spent; the expected items are queued only when record is set.
   function automatic int unsigned predict_factors(input bit [VALUE_W-1:0] value,
                                                   input bit record,
                                                   input int unsigned op_cap);
      bit [VALUE_W-1:0]  remnant;
      bit [VALUE_W-1:0]  divisor;
      bit [VALUE_W-1:0]  primes[$];
      int unsigned       ops;
      factor_result_type entry;
      remnant = value;
      divisor = 3;
      ops = 0;
      if (value == 0 || value == 1) begin
         if (record) begin
            entry.factor  = '0;
            entry.is_last = 1'b1;
            entry.status  = (value == 0) ? ST_ZERO : ST_ONE;
            expected_factors.insert(expected_factors.size(), entry);
         end
         return 0;
      end
      if (!remnant[0]) begin
         primes.insert(primes.size(), VALUE_W'(2));
         while (!remnant[0]) remnant = remnant >> 1;
      end
      while (divisor <= remnant / divisor && ops <= op_cap) begin
         ops++;
         if (remnant % divisor != 0) begin
            divisor += 2;
         end else begin
            primes.insert(primes.size(), divisor);
            while (remnant % divisor == 0) begin
               remnant = remnant / divisor;
               ops++;
            end
         end
      end
      if (remnant > 1) primes.insert(primes.size(), remnant);
      if (record) begin
         foreach (primes[i]) begin
            entry.factor  = primes[i];
            entry.is_last = (i == primes.size() - 1);
            entry.status  = ST_OK;
            expected_factors.insert(expected_factors.size(), entry);
         end
      end
      return ops;
   endfunction

   // Draws values that the block can factor in a bounded number of trial divisions.
   function automatic bit [VALUE_W-1:0] pick_value();
      longint unsigned acc;
      longint unsigned prime;
      longint unsigned cofactor;
      int unsigned     kind;
      do begin
         acc = 1;
         kind = $urandom_range(4);
         if (kind == 0) begin
            acc = $urandom;
         end else begin
            repeat ($urandom_range(1, 6)) begin
               prime = SMALL_PRIMES[$urandom_range($size(SMALL_PRIMES) - 1)];
               repeat ($urandom_range(1, 3)) begin
                  if (acc * prime <= MAX_VALUE) acc = acc * prime;
               end
            end
            if (kind == 2) begin
               repeat (40) begin
                  prime = SMALL_PRIMES[$urandom_range($size(SMALL_PRIMES) - 1)];
                  if (acc * prime <= MAX_VALUE) acc = acc * prime;
               end
            end else if (kind >= 3) begin
               cofactor = $urandom_range(2, 1 << 20);
               if (acc * cofactor <= MAX_VALUE) acc = acc * cofactor;
            end
         end
      end while (predict_factors(acc[VALUE_W-1:0], 1'b0, OP_BUDGET) > OP_BUDGET);
      return acc[VALUE_W-1:0];
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            void'(predict_factors(req_ch.value, 1'b1, NO_CAP));
            values_taken++;
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (pending_values.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               req_ch.valid <= 1'b1;
               req_ch.value <= pending_values.pop_front();
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_factors.size() == 0) begin
               error_count++;
               $display("%0t unexpected item: expected none, got factor %0d %s %0d %s %0d",
                        $time, rsp_ch.factor, "is_last", rsp_ch.is_last,
                        "status", rsp_ch.status);
            end else begin
               wanted = expected_factors.pop_front();
               if (rsp_ch.factor !== wanted.factor) begin
                  error_count++;
                  $display("%0t factor mismatch: expected %0d, got %0d",
                           $time, wanted.factor, rsp_ch.factor);
               end
               if (rsp_ch.is_last !== wanted.is_last) begin
                  error_count++;
                  $display("%0t is_last mismatch: expected %0d, got %0d",
                           $time, wanted.is_last, rsp_ch.is_last);
               end
               if (rsp_ch.status !== wanted.status) begin
                  error_count++;
                  $display("%0t status mismatch: expected %0d, got %0d",
                           $time, wanted.status, rsp_ch.status);
               end
            end
         end
         rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   initial begin
      quiet_cycles = 0;
      while (quiet_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
      end
      $display("%0t no item moved for %0d cycles", $time, STALL_LIMIT);
      $display("[distinct_prime_factor_lister_core] ERROR");
      $finish;
   end

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.value = '0;
      rsp_ch.ready = 1'b0;
      send_idle_pct = 23;
      recv_idle_pct = 75;
      values_queued = 0;
      values_taken = 0;
      error_count = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      foreach (DIRECTED_VALUES[i]) begin
         pending_values.insert(pending_values.size(), DIRECTED_VALUES[i]);
      end
      values_queued = $size(DIRECTED_VALUES);
      for (int phase = 0; phase < 3; phase++) begin
         if (phase == 1) begin
            send_idle_pct = 75;
            recv_idle_pct = 23;
         end else if (phase == 2) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         repeat (RANDOM_PER_PHASE) begin
            pending_values.insert(pending_values.size(), pick_value());
            values_queued++;
         end
         while (values_taken != values_queued || expected_factors.size() != 0) begin
            @(posedge clock);
         end
      end
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("[distinct_prime_factor_lister_core] OK");
      end else begin
         $display("[distinct_prime_factor_lister_core] ERROR");
      end
      $finish;
   end

endmodule
